// ===== hdl/laser_scan_polar_to_cartesian_core_macros.svh =====
// Assertion macros shared by the laser scan polar-to-cartesian RTL.
// Assumes clk_i and rst_ni exist in the module that uses them.
`ifndef LASER_SCAN_POLAR_TO_CARTESIAN_CORE_MACROS_SVH
`define LASER_SCAN_POLAR_TO_CARTESIAN_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset
`define LSPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
// Check that a condition never holds
`define LSPC_ASSERT_NEVER(lbl, cond, msg) \
  `LSPC_ASSERT(lbl, !(cond), msg)
`else
`define LSPC_ASSERT(lbl, prop, msg)
`define LSPC_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== hdl/lspc_pkg.sv =====
// Shared types, constants and the arctangent table for the polar-to-cartesian core.
// No dependencies.
`timescale 1ns / 1ps

package lspc_pkg;

  localparam int RangeW      = 20;
  localparam int IdxW        = 12;
  localparam int AngW        = 16;
  localparam int CoordW      = 21;
  localparam int CfgW        = 20;
  localparam int CfgIdxW     = 2;
  localparam int MaxSamples  = 4096;
  localparam int CordicSteps = 20;
  localparam int StepW       = 5;
  localparam int GainW       = 24;
  localparam int ProdW       = RangeW + GainW;
  localparam int XyW         = 31;
  localparam int ZW          = 32;

  // Gain compensation 0.60725 in Q24
  localparam logic [GainW-1:0] GainQ24 = 24'd10188014;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegMinRange   = 2'd0,
    RegMaxRange   = 2'd1,
    RegStartAngle = 2'd2,
    RegAngleStep  = 2'd3
  } lspc_reg_e;

  // Quadrant of the beam angle, in quarter turns
  typedef enum logic [1:0] {
    Quad0   = 2'd0,
    Quad90  = 2'd1,
    Quad180 = 2'd2,
    Quad270 = 2'd3
  } lspc_quad_e;

  typedef struct packed {
    logic [RangeW-1:0] min_range;
    logic [RangeW-1:0] range_max;
    logic [AngW-1:0]   start_angle;
    logic [AngW-1:0]   angle_step;
  } lspc_cfg_t;

  // Rotation state carried down the pipeline
  typedef struct packed {
    logic signed [XyW-1:0] x;
    logic signed [XyW-1:0] y;
    logic signed [ZW-1:0]  z;
    lspc_quad_e            quad;
    logic [IdxW-1:0]       idx;
  } lspc_rot_t;

  // Arctangent of 2^-step in 2^-32 turn units
  function automatic logic signed [ZW-1:0] atan_angle(input logic [StepW-1:0] step);
    logic signed [ZW-1:0] val;
    case (step)
      5'd0:    val = 32'sh20000000;
      5'd1:    val = 32'sh12E4051E;
      5'd2:    val = 32'sh09FB385B;
      5'd3:    val = 32'sh051111D4;
      5'd4:    val = 32'sh028B0D43;
      5'd5:    val = 32'sh0145D7E1;
      5'd6:    val = 32'sh00A2F61E;
      5'd7:    val = 32'sh00517C55;
      5'd8:    val = 32'sh0028BE53;
      5'd9:    val = 32'sh00145F2F;
      5'd10:   val = 32'sh000A2F98;
      5'd11:   val = 32'sh000517CC;
      5'd12:   val = 32'sh00028BE6;
      5'd13:   val = 32'sh000145F3;
      5'd14:   val = 32'sh0000A2FA;
      5'd15:   val = 32'sh0000517D;
      5'd16:   val = 32'sh000028BE;
      5'd17:   val = 32'sh0000145F;
      5'd18:   val = 32'sh00000A30;
      5'd19:   val = 32'sh00000518;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ===== hdl/lspc_stream_if.sv =====
// Valid/ready stream interfaces for range samples and cartesian points.
// Depends on lspc_pkg.
`timescale 1ns / 1ps

interface lspc_sample_if;
  logic                        valid;
  logic                        ready;
  logic [lspc_pkg::RangeW-1:0] range_sample;
  logic [lspc_pkg::IdxW-1:0]   sample_index;

  modport source (output valid, output range_sample, output sample_index, input ready);
  modport sink   (input valid, input range_sample, input sample_index, output ready);
endinterface

interface lspc_point_if;
  logic                               valid;
  logic                               ready;
  logic signed [lspc_pkg::CoordW-1:0] point_x;
  logic signed [lspc_pkg::CoordW-1:0] point_y;
  logic [lspc_pkg::IdxW-1:0]          point_index;

  modport source (output valid, output point_x, output point_y, output point_index,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input point_index,
                  output ready);
endinterface

// ===== hdl/lspc_front.sv =====
// Front end: range window filter, gain multiply and beam angle (stage 1),
// start vector and quadrant split (stage 2). Depends on lspc_pkg, lspc_stream_if.
`timescale 1ns / 1ps
`include "laser_scan_polar_to_cartesian_core_macros.svh"

module lspc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lspc_pkg::lspc_cfg_t cfg_i,
  lspc_sample_if.sink         sample_i,
  output logic                valid_o,
  input  logic                ready_i,
  output lspc_pkg::lspc_rot_t data_o
);
  import lspc_pkg::*;

  localparam int AngProdW = AngW + IdxW;
  localparam logic signed [ZW-1:0] ZMax = 32'sd536805376;
  localparam logic signed [ZW-1:0] ZMin = -32'sd536870912;

  logic                v1_q, v2_q;
  logic                ready1, ready2;
  logic                keep;
  logic [ProdW-1:0]    prod_d, prod_q;
  logic [AngW-1:0]     ang_d, ang_q;
  logic [IdxW-1:0]     idx1_q;
  logic [AngProdW-1:0] step_prod;
  logic [ProdW-1:0]    prod_rnd;
  logic [AngW-1:0]     ang_bias;
  logic [AngW-1:0]     resid;
  lspc_rot_t           d2_d, d2_q;

  // Bubble-collapsing ready chain
  assign ready2         = !v2_q || ready_i;
  assign ready1         = !v1_q || ready2;
  assign sample_i.ready = ready1;

  // Window and scan length check
  assign keep = (int'(sample_i.sample_index) < MaxSamples) &&
                (sample_i.range_sample >= cfg_i.min_range) &&
                (sample_i.range_sample <= cfg_i.range_max);

  // Gain multiply and beam angle modulo a full turn
  assign prod_d    = ProdW'(sample_i.range_sample) * ProdW'(GainQ24);
  assign step_prod = AngProdW'(cfg_i.angle_step) * AngProdW'(sample_i.sample_index);
  assign ang_d     = cfg_i.start_angle + step_prod[AngW-1:0];

  // Stage 1 registers; drop samples outside the window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (ready1) begin
      v1_q <= sample_i.valid && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.valid && ready1) begin
      prod_q <= prod_d;
      ang_q  <= ang_d;
      idx1_q <= sample_i.sample_index;
    end
  end

  // Round the start magnitude and split the angle into quadrant and residual
  always_comb begin
    prod_rnd    = prod_q + ProdW'(32768);
    ang_bias    = ang_q + AngW'(16'h2000);
    d2_d.quad   = lspc_quad_e'(ang_bias[AngW-1:AngW-2]);
    resid       = ang_q - {ang_bias[AngW-1:AngW-2], {(AngW-2){1'b0}}};
    d2_d.x      = XyW'(prod_rnd[ProdW-1:16]);
    d2_d.y      = '0;
    d2_d.z      = {resid, {(ZW-AngW){1'b0}}};
    d2_d.idx    = idx1_q;
  end

  // Stage 2 registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (ready2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q && ready2) begin
      d2_q <= d2_d;
    end
  end

  assign valid_o = v2_q;
  assign data_o  = d2_q;

  `LSPC_ASSERT(a_drop_outside_window, (sample_i.valid && sample_i.ready && ((sample_i.range_sample < cfg_i.min_range) || (sample_i.range_sample > cfg_i.range_max))) |=> !v1_q, "sample outside range window entered pipeline")
  `LSPC_ASSERT(a_residual_in_octant, v2_q |-> ((d2_q.z >= ZMin) && (d2_q.z <= ZMax)), "angle residual outside one eighth turn")

endmodule

// ===== hdl/lspc_cordic_stage.sv =====
// One registered rotation-mode CORDIC iteration with its own valid/ready.
// Depends on lspc_pkg.
`timescale 1ns / 1ps

module lspc_cordic_stage #(
  parameter int STEP = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  lspc_pkg::lspc_rot_t data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output lspc_pkg::lspc_rot_t data_o
);
  import lspc_pkg::*;

  localparam logic signed [ZW-1:0] Atan = atan_angle(StepW'(STEP));

  logic                  valid_q;
  logic signed [XyW-1:0] dx, dy;
  lspc_rot_t             data_d, data_q;

  assign ready_o = !valid_q || ready_i;

  // Rotate toward zero residual angle
  always_comb begin
    dx     = data_i.y >>> STEP;
    dy     = data_i.x >>> STEP;
    data_d = data_i;
    if (!data_i.z[ZW-1]) begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - Atan;
    end else begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Hold the payload while stalled
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hdl/lspc_back.sv =====
// Back end: quarter-turn rotation, rounding, saturation and output register.
// Depends on lspc_pkg, lspc_stream_if.
`timescale 1ns / 1ps

module lspc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  lspc_pkg::lspc_rot_t data_i,
  lspc_point_if.source        point_o
);
  import lspc_pkg::*;

  localparam int WideW = XyW + 1;
  localparam int ShW   = WideW - 8;
  localparam logic signed [ShW-1:0] CoordMax = ShW'((1 << (CoordW - 1)) - 1);
  localparam logic signed [ShW-1:0] CoordMin = -ShW'(1 << (CoordW - 1));

  logic                     valid_q;
  logic signed [WideW-1:0]  c, s, px, py;
  logic signed [CoordW-1:0] x_d, y_d, x_q, y_q;
  logic [IdxW-1:0]          idx_q;

  function automatic logic signed [CoordW-1:0] finish(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] sum;
    logic signed [ShW-1:0]   sh;
    logic signed [CoordW-1:0] res;
    sum = v + WideW'(128);
    sh  = ShW'(sum >>> 8);
    if (sh > CoordMax) begin
      res = CoordMax[CoordW-1:0];
    end else if (sh < CoordMin) begin
      res = CoordMin[CoordW-1:0];
    end else begin
      res = sh[CoordW-1:0];
    end
    return res;
  endfunction

  assign ready_o = !valid_q || point_o.ready;

  // Rotate by whole quarter turns, then round and saturate
  always_comb begin
    c = WideW'(data_i.x);
    s = WideW'(data_i.y);
    case (data_i.quad)
      Quad0:   begin px = c;  py = s;  end
      Quad90:  begin px = -s; py = c;  end
      Quad180: begin px = -c; py = -s; end
      Quad270: begin px = s;  py = -c; end
      default: begin px = c;  py = s;  end
    endcase
    x_d = finish(px);
    y_d = finish(py);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      x_q   <= x_d;
      y_q   <= y_d;
      idx_q <= data_i.idx;
    end
  end

  assign point_o.valid       = valid_q;
  assign point_o.point_x     = x_q;
  assign point_o.point_y     = y_q;
  assign point_o.point_index = idx_q;

endmodule

// ===== hdl/laser_scan_polar_to_cartesian_core.sv =====
// Pipeline from sample transaction to point valid: 2 front stages,
// 20 CORDIC iteration stages and 1 output stage; one stage per rotation step.
// Throughput: one sample per cycle; stalls collapse bubbles stage by stage.
// Samples outside the range window or scan length produce no point.
// Reset (rst_ni, async low) empties the pipeline and loads register defaults.
`timescale 1ns / 1ps
`include "laser_scan_polar_to_cartesian_core_macros.svh"

module laser_scan_polar_to_cartesian_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lspc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [lspc_pkg::CfgW-1:0]    cfg_wdata_i,
  lspc_sample_if.sink                 sample_i,
  lspc_point_if.source                point_o
);
  import lspc_pkg::*;

  lspc_cfg_t cfg_q;
  logic [CordicSteps:0] vld;
  logic [CordicSteps:0] rdy;
  lspc_rot_t            dat [CordicSteps+1];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_range   <= '0;
      cfg_q.range_max   <= '1;
      cfg_q.start_angle <= '0;
      cfg_q.angle_step  <= AngW'(16);
    end else if (cfg_we_i) begin
      case (lspc_reg_e'(cfg_index_i))
        RegMinRange:   cfg_q.min_range   <= cfg_wdata_i[RangeW-1:0];
        RegMaxRange:   cfg_q.range_max   <= cfg_wdata_i[RangeW-1:0];
        RegStartAngle: cfg_q.start_angle <= cfg_wdata_i[AngW-1:0];
        RegAngleStep:  cfg_q.angle_step  <= cfg_wdata_i[AngW-1:0];
        default: ;
      endcase
    end
  end

  lspc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .sample_i (sample_i),
    .valid_o  (vld[0]),
    .ready_i  (rdy[0]),
    .data_o   (dat[0])
  );

  // Rotation pipeline, one iteration per stage
  for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
    lspc_cordic_stage #(.STEP(i)) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[i]),
      .ready_o (rdy[i]),
      .data_i  (dat[i]),
      .valid_o (vld[i+1]),
      .ready_i (rdy[i+1]),
      .data_o  (dat[i+1])
    );
  end

  lspc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld[CordicSteps]),
    .ready_o (rdy[CordicSteps]),
    .data_i  (dat[CordicSteps]),
    .point_o (point_o)
  );

  `LSPC_ASSERT(a_backpressure_only_when_full, !sample_i.ready |-> ((&vld) && point_o.valid), "input stalled while the pipeline has a free slot")

endmodule
